// ===== rtl/core/hctp_pkg.sv =====
// shared types, character codes and classifier helpers for the content-type parser
`timescale 1ns / 1ps

package hctp_pkg;

	// byte kind codes
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_TYPE  = 2'd1;
	localparam logic [1:0] KIND_NAME  = 2'd2;
	localparam logic [1:0] KIND_VALUE = 2'd3;

	// grammar characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_EQUAL  = 8'h3d;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_DEL    = 8'h7f;

	// character classes of one byte
	typedef struct packed {
		logic zero;
		logic lws;
		logic token;
		logic text;
		logic chr;
	} cls_t;

	// one result beat
	typedef struct packed {
		logic       parse_error;
		logic       header_done;
		logic       attribute_end;
		logic       name_end;
		logic       type_end;
		logic [1:0] byte_kind;
		logic [7:0] data_byte;
	} res_t;

	// separators excluded from tokens
	function automatic logic is_separator(input logic [7:0] c);
		logic sep;
		case (c)
			8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c,
			8'h22, 8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d: sep = 1'b1;
			default: sep = 1'b0;
		endcase
		return sep;
	endfunction

endpackage

// ===== rtl/core/hctp_class.sv =====
// character class decode for one header byte
`timescale 1ns / 1ps

module hctp_class (
	input  logic [7:0]    in_byte,
	output hctp_pkg::cls_t cls
);

	// printable range without separators is a token character
	always_comb begin
		cls.zero  = (in_byte == hctp_pkg::CH_NUL);
		cls.lws   = (in_byte == hctp_pkg::CH_SPACE) || (in_byte == hctp_pkg::CH_TAB) ||
		            (in_byte == hctp_pkg::CH_LF) || (in_byte == hctp_pkg::CH_CR);
		cls.token = (in_byte > hctp_pkg::CH_SPACE) && (in_byte < hctp_pkg::CH_DEL) &&
		            !hctp_pkg::is_separator(in_byte);
		cls.text  = (in_byte == hctp_pkg::CH_TAB) || (in_byte == hctp_pkg::CH_LF) ||
		            (in_byte == hctp_pkg::CH_CR) ||
		            ((in_byte >= hctp_pkg::CH_SPACE) && (in_byte != hctp_pkg::CH_DEL));
		cls.chr   = !in_byte[7];
	end

endmodule

// ===== rtl/core/hctp_fsm.sv =====
// grammar state machine: phase and sticky error, one byte per step
`timescale 1ns / 1ps

module hctp_fsm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     in_byte,
	input  hctp_pkg::cls_t cls,
	output hctp_pkg::res_t res
);

	typedef enum logic [3:0] {
		PH_LEAD        = 4'd0,
		PH_TYPE        = 4'd1,
		PH_SUB_FIRST   = 4'd2,
		PH_SUB         = 4'd3,
		PH_GAP         = 4'd4,
		PH_AFTER_SEMI  = 4'd5,
		PH_NAME        = 4'd6,
		PH_VALUE_START = 4'd7,
		PH_VTOKEN      = 4'd8,
		PH_QUOTED      = 4'd9,
		PH_ESCAPE      = 4'd10
	} phase_t;

	phase_t phase_q, phase_nxt, ai_phase;
	logic   err_q, err_nxt;
	logic   ai_done, ai_err;

	// judgment of the byte after a finished type or value
	always_comb begin
		ai_phase = phase_q;
		ai_done  = 1'b0;
		ai_err   = 1'b0;
		if (cls.lws) begin
			ai_phase = PH_GAP;
		end else if (cls.zero) begin
			ai_done  = 1'b1;
			ai_phase = PH_LEAD;
		end else if (in_byte == hctp_pkg::CH_SEMI) begin
			ai_phase = PH_AFTER_SEMI;
		end else begin
			ai_err = 1'b1;
		end
	end

	// result and next phase
	always_comb begin
		res       = '0;
		phase_nxt = phase_q;
		err_nxt   = err_q;
		if (err_q) begin
			res.parse_error = 1'b1;
			if (cls.zero) begin
				err_nxt   = 1'b0;
				phase_nxt = PH_LEAD;
			end
		end else begin
			unique case (phase_q)
				PH_TYPE: begin
					if (cls.token) begin
						res.data_byte = in_byte;
						res.byte_kind = hctp_pkg::KIND_TYPE;
					end else if (in_byte == hctp_pkg::CH_SLASH) begin
						res.data_byte = in_byte;
						res.byte_kind = hctp_pkg::KIND_TYPE;
						phase_nxt     = PH_SUB_FIRST;
					end else begin
						res.parse_error = 1'b1;
					end
				end
				PH_SUB_FIRST: begin
					if (cls.token) begin
						res.data_byte = in_byte;
						res.byte_kind = hctp_pkg::KIND_TYPE;
						phase_nxt     = PH_SUB;
					end else begin
						res.parse_error = 1'b1;
					end
				end
				PH_SUB: begin
					if (cls.token) begin
						res.data_byte = in_byte;
						res.byte_kind = hctp_pkg::KIND_TYPE;
					end else begin
						res.type_end    = 1'b1;
						res.header_done = ai_done;
						res.parse_error = ai_err;
						phase_nxt       = ai_phase;
					end
				end
				PH_GAP: begin
					if (!cls.lws) begin
						res.header_done = ai_done;
						res.parse_error = ai_err;
						phase_nxt       = ai_phase;
					end
				end
				PH_AFTER_SEMI: begin
					if (cls.token) begin
						res.data_byte = in_byte;
						res.byte_kind = hctp_pkg::KIND_NAME;
						phase_nxt     = PH_NAME;
					end else if (!cls.lws) begin
						res.parse_error = 1'b1;
					end
				end
				PH_NAME: begin
					if (cls.token) begin
						res.data_byte = in_byte;
						res.byte_kind = hctp_pkg::KIND_NAME;
					end else if (in_byte == hctp_pkg::CH_EQUAL) begin
						res.name_end = 1'b1;
						phase_nxt    = PH_VALUE_START;
					end else begin
						res.parse_error = 1'b1;
					end
				end
				PH_VALUE_START: begin
					if (in_byte == hctp_pkg::CH_DQUOTE) begin
						phase_nxt = PH_QUOTED;
					end else if (cls.token) begin
						res.data_byte = in_byte;
						res.byte_kind = hctp_pkg::KIND_VALUE;
						phase_nxt     = PH_VTOKEN;
					end else begin
						res.parse_error = 1'b1;
					end
				end
				PH_VTOKEN: begin
					if (cls.token) begin
						res.data_byte = in_byte;
						res.byte_kind = hctp_pkg::KIND_VALUE;
					end else begin
						res.attribute_end = 1'b1;
						res.header_done   = ai_done;
						res.parse_error   = ai_err;
						phase_nxt         = ai_phase;
					end
				end
				PH_QUOTED: begin
					if (in_byte == hctp_pkg::CH_DQUOTE) begin
						res.attribute_end = 1'b1;
						phase_nxt         = PH_GAP;
					end else if (in_byte == hctp_pkg::CH_BSLASH) begin
						phase_nxt = PH_ESCAPE;
					end else if (cls.text) begin
						res.data_byte = in_byte;
						res.byte_kind = hctp_pkg::KIND_VALUE;
					end else begin
						res.parse_error = 1'b1;
					end
				end
				PH_ESCAPE: begin
					if (!cls.zero && cls.chr) begin
						res.data_byte = in_byte;
						res.byte_kind = hctp_pkg::KIND_VALUE;
						phase_nxt     = PH_QUOTED;
					end else begin
						res.parse_error = 1'b1;
					end
				end
				// leading whitespace, also any unused code
				default: begin
					if (cls.token) begin
						res.data_byte = in_byte;
						res.byte_kind = hctp_pkg::KIND_TYPE;
						phase_nxt     = PH_TYPE;
					end else if (cls.lws) begin
						phase_nxt = PH_LEAD;
					end else begin
						res.parse_error = 1'b1;
					end
				end
			endcase
			// any error restarts; a nonzero byte leaves it latched
			if (res.parse_error) begin
				phase_nxt = PH_LEAD;
				err_nxt   = !cls.zero;
			end
		end
	end

	// phase and error state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_nxt;
			err_q   <= err_nxt;
		end
	end

	// sticky error gives nothing but the error flag
	assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> (res.parse_error && res.byte_kind == hctp_pkg::KIND_NONE))
		else $error("latched error lets content through");

	// no content byte without a kind
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.byte_kind == hctp_pkg::KIND_NONE) |-> (res.data_byte == 8'h00))
		else $error("data byte set with no kind");

	// completion only on the terminator and never with an error
	assert property (@(posedge clk) disable iff (!arst_n)
		res.header_done |-> (cls.zero && !res.parse_error))
		else $error("header done off the terminator");

	// an error step on a nonzero byte leaves the error latched
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.parse_error && !cls.zero) |=> err_q)
		else $error("error not latched");

endmodule

// ===== rtl/core/http_content_type_parser.sv =====
// top level of the streaming content-type header parser
//
//  channel | dir | beat fields (low bit up)
//  --------+-----+-------------------------------------------------------------
//  s_*     | in  | tdata: in_byte[7:0]
//  m_*     | out | tdata: data_byte[7:0]; tuser: byte_kind[1:0], type_end,
//          |     |        name_end, attribute_end, header_done, parse_error
//
// one beat in, one beat out; a new byte is taken every cycle while a stalled output does not block the input register
// each byte passes through the input register, then the result register
// the phase register updates as a byte moves into the result register
// a stalled output holds its beat and stops the input register in place
// reset clears the phase, the sticky error and both valid flags
`timescale 1ns / 1ps

module http_content_type_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte[7:0]
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // data_byte[7:0]
	output logic [6:0] m_tuser    // byte_kind[1:0], type_end, name_end,
	                              // attribute_end, header_done, parse_error
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           out_valid_q;
	hctp_pkg::res_t res_q;
	hctp_pkg::res_t res;
	hctp_pkg::cls_t cls;
	logic           advance;
	logic           step;
	logic           take;

	// handshake
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;
	assign take     = s_tvalid && s_tready;

	hctp_class u_class (
		.in_byte (byte_s1),
		.cls     (cls)
	);

	hctp_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_byte (byte_s1),
		.cls     (cls),
		.res     (res)
	);

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= s_tdata;
		end
		if (step) begin
			res_q <= res;
		end
	end

	// output beat
	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q.data_byte;
	assign m_tuser  = {res_q.parse_error, res_q.header_done, res_q.attribute_end,
	                   res_q.name_end, res_q.type_end, res_q.byte_kind};

	// a byte in the input register moves out whenever the output frees up
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> out_valid_q)
		else $error("stepped byte produced no result");

	// a held output beat keeps its contents
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(res_q)))
		else $error("stalled result changed");

	// input stays blocked only while both stages are full
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without cause");

endmodule

// ===== test/http_content_type_parser_tb.sv =====
// self-checking testbench for the streaming content-type header parser
`timescale 1ns / 1ps

import hctp_pkg::*;

// grammar position of the parser
typedef enum logic [3:0] {
	G_LEAD,
	G_TYPE,
	G_SUB_FIRST,
	G_SUB,
	G_GAP,
	G_AFTER_SEMI,
	G_NAME,
	G_VALUE_START,
	G_VTOKEN,
	G_QUOTED,
	G_ESCAPE
} grammar_phase_t;

// token characters: visible ascii without the separators
function automatic bit is_tok(logic [7:0] c);
	bit ok;
	ok = (c >= 8'd33 && c <= 8'd126);
	case (c)
		"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/",
		"[", "]", "?", "=", "{", "}": ok = 1'b0;
		default: ;
	endcase
	return ok;
endfunction

function automatic bit is_lws(logic [7:0] c);
	return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
endfunction

function automatic bit is_text(logic [7:0] c);
	return c == CH_TAB || c == CH_CR || c == CH_LF || (c >= CH_SPACE && c != CH_DEL);
endfunction

// predicts one result beat per header byte and checks the output stream
class header_scoreboard;
	grammar_phase_t phase;
	bit             sticky_err;
	res_t           expected_q[$];
	int unsigned    n_checked;
	int unsigned    n_errors;
	int unsigned    n_done;

	function new();
		phase      = G_LEAD;
		sticky_err = 1'b0;
		n_checked  = 0;
		n_errors   = 0;
		n_done     = 0;
	endfunction

	// next-state and output of the grammar checker for one byte
	function res_t predict(logic [7:0] c);
		res_t r;
		bit   follows;   // byte that comes after a finished type or value
		r       = '0;
		follows = 1'b0;
		if (sticky_err) begin
			r.parse_error = 1'b1;
			if (c == CH_NUL) begin
				sticky_err = 1'b0;
				phase      = G_LEAD;
			end
			return r;
		end
		case (phase)
			G_TYPE: begin
				if (is_tok(c) || c == CH_SLASH) begin
					r.data_byte = c;
					r.byte_kind = KIND_TYPE;
					if (c == CH_SLASH)
						phase = G_SUB_FIRST;
				end else
					r.parse_error = 1'b1;
			end
			G_SUB_FIRST: begin
				if (is_tok(c)) begin
					r.data_byte = c;
					r.byte_kind = KIND_TYPE;
					phase       = G_SUB;
				end else
					r.parse_error = 1'b1;
			end
			G_SUB: begin
				if (is_tok(c)) begin
					r.data_byte = c;
					r.byte_kind = KIND_TYPE;
				end else begin
					r.type_end = 1'b1;
					follows    = 1'b1;
				end
			end
			G_GAP: begin
				follows = !is_lws(c);
			end
			G_AFTER_SEMI: begin
				if (is_tok(c)) begin
					r.data_byte = c;
					r.byte_kind = KIND_NAME;
					phase       = G_NAME;
				end else if (!is_lws(c))
					r.parse_error = 1'b1;
			end
			G_NAME: begin
				if (is_tok(c)) begin
					r.data_byte = c;
					r.byte_kind = KIND_NAME;
				end else if (c == CH_EQUAL) begin
					r.name_end = 1'b1;
					phase      = G_VALUE_START;
				end else
					r.parse_error = 1'b1;
			end
			G_VALUE_START: begin
				if (c == CH_DQUOTE)
					phase = G_QUOTED;
				else if (is_tok(c)) begin
					r.data_byte = c;
					r.byte_kind = KIND_VALUE;
					phase       = G_VTOKEN;
				end else
					r.parse_error = 1'b1;
			end
			G_VTOKEN: begin
				if (is_tok(c)) begin
					r.data_byte = c;
					r.byte_kind = KIND_VALUE;
				end else begin
					r.attribute_end = 1'b1;
					follows         = 1'b1;
				end
			end
			G_QUOTED: begin
				if (c == CH_DQUOTE) begin
					r.attribute_end = 1'b1;
					phase           = G_GAP;
				end else if (c == CH_BSLASH)
					phase = G_ESCAPE;
				else if (is_text(c)) begin
					r.data_byte = c;
					r.byte_kind = KIND_VALUE;
				end else
					r.parse_error = 1'b1;
			end
			G_ESCAPE: begin
				if (c != CH_NUL && c[7] == 1'b0) begin
					r.data_byte = c;
					r.byte_kind = KIND_VALUE;
					phase       = G_QUOTED;
				end else
					r.parse_error = 1'b1;
			end
			default: begin
				if (is_tok(c)) begin
					r.data_byte = c;
					r.byte_kind = KIND_TYPE;
					phase       = G_TYPE;
				end else if (is_lws(c))
					phase = G_LEAD;
				else
					r.parse_error = 1'b1;
			end
		endcase
		// judge what comes after a type or value
		if (follows) begin
			if (is_lws(c))
				phase = G_GAP;
			else if (c == CH_NUL) begin
				r.header_done = 1'b1;
				phase         = G_LEAD;
			end else if (c == CH_SEMI)
				phase = G_AFTER_SEMI;
			else
				r.parse_error = 1'b1;
		end
		if (r.parse_error) begin
			phase      = G_LEAD;
			sticky_err = (c != CH_NUL);
		end
		return r;
	endfunction

	function void note_input(logic [7:0] c);
		expected_q.push_back(predict(c));
	endfunction

	function void cmp_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0h, got %0h", field, want, got);
			n_errors++;
		end
	endfunction

	function void check_result(res_t got);
		res_t want;
		if (expected_q.size() == 0) begin
			$error("result beat with nothing expected: data_byte %0h", got.data_byte);
			n_errors++;
			return;
		end
		want = expected_q.pop_front();
		n_checked++;
		cmp_field("data_byte", want.data_byte, got.data_byte);
		cmp_field("byte_kind", want.byte_kind, got.byte_kind);
		cmp_field("type_end", want.type_end, got.type_end);
		cmp_field("name_end", want.name_end, got.name_end);
		cmp_field("attribute_end", want.attribute_end, got.attribute_end);
		cmp_field("header_done", want.header_done, got.header_done);
		cmp_field("parse_error", want.parse_error, got.parse_error);
		if (got.header_done)
			n_done++;
	endfunction
endclass

module http_content_type_parser_tb;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int          RANDOM_BYTES = 2000;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          HOLD_AFTER   = 600;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;   // in_byte[7:0]
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // data_byte[7:0]
	logic [6:0] m_tuser;            // byte_kind[1:0], type_end, name_end,
	                                // attribute_end, header_done, parse_error

	header_scoreboard sb;
	int unsigned      cycle_count = 0;
	int unsigned      n_sent      = 0;
	int unsigned      n_headers   = 0;
	int unsigned      n_bad       = 0;
	bit               holding     = 1'b0;
	bit               hold_done   = 1'b0;
	bit               burst_tx    = 1'b0;

	http_content_type_parser u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic logic [7:0] rand_token();
		logic [7:0] c;
		do
			c = 8'($urandom_range(33, 126));
		while (!is_tok(c));
		return c;
	endfunction

	function automatic logic [7:0] rand_lws();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	// plain quoted-string content, quote and backslash excluded
	function automatic logic [7:0] rand_qtext();
		logic [7:0] c;
		do
			c = 8'($urandom_range(9, 255));
		while (!is_text(c) || c == CH_DQUOTE || c == CH_BSLASH);
		return c;
	endfunction

	// offer one beat and wait for the handshake
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = (holding || burst_tx) ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(b);
		n_sent++;
	endtask

	// one random header: mostly well formed, some corrupted, a few pure noise
	task automatic send_header();
		logic [7:0] h[$];
		int         style;
		int         pos;
		int         n;
		style = $urandom_range(0, 99);
		if (style < 6) begin
			n = $urandom_range(1, 12);
			repeat (n) h.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 2)) h.push_back(rand_lws());
			repeat ($urandom_range(1, 4)) h.push_back(rand_token());
			h.push_back(CH_SLASH);
			repeat ($urandom_range(1, 4)) h.push_back(rand_token());
			repeat ($urandom_range(0, 3)) begin
				repeat ($urandom_range(0, 2)) h.push_back(rand_lws());
				h.push_back(CH_SEMI);
				repeat ($urandom_range(0, 2)) h.push_back(rand_lws());
				repeat ($urandom_range(1, 4)) h.push_back(rand_token());
				h.push_back(CH_EQUAL);
				if ($urandom_range(0, 1)) begin
					repeat ($urandom_range(1, 4)) h.push_back(rand_token());
				end else begin
					h.push_back(CH_DQUOTE);
					repeat ($urandom_range(0, 5)) begin
						if ($urandom_range(0, 3) == 0) begin
							h.push_back(CH_BSLASH);
							h.push_back(8'($urandom_range(1, 127)));
						end else
							h.push_back(rand_qtext());
					end
					h.push_back(CH_DQUOTE);
				end
			end
			repeat ($urandom_range(0, 2)) h.push_back(rand_lws());
			// break the sequence at a random spot
			if (style >= 80) begin
				pos = $urandom_range(0, h.size() - 1);
				if ($urandom_range(0, 1))
					h[pos] = 8'($urandom_range(0, 255));
				else
					while (h.size() > pos)
						void'(h.pop_back());
				n_bad++;
			end
		end
		h.push_back(CH_NUL);
		burst_tx = ($urandom_range(0, 7) == 0);
		foreach (h[i])
			send_byte(h[i]);
		n_headers++;
	endtask

	// output stall pattern, with one long hold-off while input keeps coming
	initial begin
		int run;
		int stall;
		int hold_count;
		@(posedge arst_n);
		forever begin
			if (!hold_done && n_sent >= HOLD_AFTER) begin
				holding    = 1'b1;
				hold_count = 0;
				m_tready <= 1'b0;
				while (hold_count < HOLD_CYCLES) begin
					@(posedge clk);
					hold_count++;
				end
				holding   = 1'b0;
				hold_done = 1'b1;
			end
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// result monitor
	initial begin
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result({m_tuser, m_tdata});
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// main sequence
	initial begin
		logic [7:0] directed [0:25];
		sb = new();
		// empty header; lws, type, name, token value; quoted value with
		// high text byte and escaped quote; bad byte after slash then sticky
		directed = '{
			8'h00,
			8'h09, "a", "/", "b", ";", "!", "=", "~", 8'h00,
			"x", "/", "y", ";", "n", "=", "\"", 8'h80, "\\", "\"", "\"", 8'h00,
			"a", "/", 8'hff, 8'h00
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_byte(directed[i]);
		while (n_sent < RANDOM_BYTES + 26)
			send_header();
		s_tvalid <= 1'b0;
		// drain
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("sent %0d header bytes in %0d headers (%0d corrupted), checked %0d beats",
			n_sent, n_headers, n_bad, sb.n_checked);
		$display("%0d headers completed; output held off %0d cycles once under full input",
			sb.n_done, HOLD_CYCLES);
		if (sb.n_errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
